@@ hw/rtl/bta_pkg.sv @@
// Shared types and codes for the buddy tree page allocator.
// No dependencies; imported by bta_ctrl, bta_dp and the top level.
package bta_pkg;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NO_SPACE  = 2'd1,
        STATUS_MALFORMED = 2'd2
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // controller -> datapath, at most one step per cycle
    typedef struct packed {
        logic clear;
        logic capture;
        logic check;
        logic look;
        logic descend;
        logic mark;
        logic ascend;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic chk_fail;
        logic look_fail;
        logic reach_now;
        logic reach_next;
        logic at_root;
        logic parent_root;
    } sts_t;

endpackage

@@ hw/rtl/bta_ctrl.sv @@
// Sequencer for the buddy tree allocator: clearing pass, request capture and check,
// root look, descent, marking, ascent and result hand-off. Depends on bta_pkg.
module bta_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          out_free,
    input  bta_pkg::sts_t sts,
    output bta_pkg::cmd_t cmd
);
    import bta_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_CHECK   = 8'b0000_0100,
        S_LOOK    = 8'b0000_1000,
        S_DESCEND = 8'b0001_0000,
        S_MARK    = 8'b0010_0000,
        S_ASCEND  = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.chk_fail ? S_FINISH : S_LOOK;
            end
            S_LOOK: begin
                cmd.look = 1'b1;
                priority if (sts.look_fail) state_next = S_FINISH;
                else if (sts.reach_now)     state_next = S_MARK;
                else                        state_next = S_DESCEND;
            end
            S_DESCEND: begin
                cmd.descend = 1'b1;
                if (sts.reach_next) state_next = S_MARK;
            end
            S_MARK: begin
                cmd.mark   = 1'b1;
                state_next = sts.at_root ? S_FINISH : S_ASCEND;
            end
            S_ASCEND: begin
                cmd.ascend = 1'b1;
                if (sts.parent_root) state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/bta_dp.sv @@
// Datapath of the buddy tree allocator: tree memory (one read, one write
// port), node index walker, merge logic and free page count. Depends on bta_pkg.
module bta_dp #(
    parameter int POOL_ORDER = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bta_pkg::cmd_t           cmd,
    output bta_pkg::sts_t           sts,
    input  logic                    in_op,
    input  logic [POOL_ORDER:0]     in_count,
    input  logic [POOL_ORDER-1:0]   in_offset,
    output bta_pkg::status_t        res_status,
    output logic [POOL_ORDER-1:0]   res_offset,
    output logic [POOL_ORDER:0]     res_pages,
    output logic [POOL_ORDER:0]     res_free
);
    import bta_pkg::*;

    localparam int IW    = POOL_ORDER + 1;
    localparam int NW    = POOL_ORDER + 1;
    localparam int KW    = $clog2(POOL_ORDER + 2);
    localparam int SLOTS = 2 ** IW;
    localparam logic [NW-1:0] POOL = {1'b1, {POOL_ORDER{1'b0}}};

    logic [NW-1:0] tree_mem [SLOTS];

    logic                  op_reg;
    logic [NW-1:0]         count_reg;
    logic [POOL_ORDER-1:0] offset_reg;
    logic [KW-1:0]         k_reg, k_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [NW-1:0]         size_reg, size_next;
    logic [NW-1:0]         val_reg, val_next;
    logic [NW-1:0]         total_reg, total_next;
    logic [POOL_ORDER-1:0] boff_reg, boff_next;
    status_t               status_reg, status_next;
    logic [IW-1:0]         clr_reg;
    logic [NW-1:0]         rd_reg;

    logic [NW-1:0]         cm1;
    logic [KW-1:0]         k_calc;
    status_t               chk_code;
    logic [IW-1:0]         free_idx, left_idx, desc_idx, sib_idx, par_idx, par_sib;
    logic                  look_fail;
    logic [NW-1:0]         psize, lval, rval, mx, merged, mark_val;
    logic [NW:0]           sum;
    logic [IW-1:0]         off_full;
    logic [IW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;
    logic [NW-1:0]         wr_data;

    // ceil(log2(count)) from the highest set bit of count-1
    always_comb begin
        cm1    = count_reg - NW'(1);
        k_calc = '0;
        for (int i = 0; i < NW; i++) begin
            if (cm1[i]) k_calc = KW'(i + 1);
        end
    end

    always_comb begin
        priority if (count_reg == '0) begin
            chk_code = STATUS_MALFORMED;
        end else if (op_reg == OP_ALLOC) begin
            chk_code = (count_reg > POOL) ? STATUS_NO_SPACE : STATUS_DONE;
        end else if (count_reg > POOL || (count_reg & cm1) != '0 ||
                     (offset_reg & cm1[POOL_ORDER-1:0]) != '0) begin
            chk_code = STATUS_MALFORMED;
        end else begin
            chk_code = STATUS_DONE;
        end
    end

    assign free_idx  = ({1'b1, offset_reg} >> k_calc) - IW'(1);
    assign look_fail = (op_reg == OP_ALLOC) ? (rd_reg < n_reg) : (rd_reg != '0);
    assign left_idx  = {idx_reg[IW-2:0], 1'b1};
    assign desc_idx  = (rd_reg >= n_reg) ? left_idx : left_idx + IW'(1);
    assign sib_idx   = idx_reg[0] ? idx_reg + IW'(1) : idx_reg - IW'(1);
    assign par_idx   = (idx_reg - IW'(1)) >> 1;
    assign par_sib   = par_idx[0] ? par_idx + IW'(1) : par_idx - IW'(1);
    assign psize     = size_reg << 1;
    assign lval      = idx_reg[0] ? val_reg : rd_reg;
    assign rval      = idx_reg[0] ? rd_reg : val_reg;
    assign sum       = {1'b0, lval} + {1'b0, rval};
    assign mx        = (lval > rval) ? lval : rval;
    assign merged    = (op_reg == OP_FREE && sum == {1'b0, psize}) ? psize : mx;
    assign mark_val  = (op_reg == OP_ALLOC) ? '0 : n_reg;
    assign off_full  = (idx_reg + IW'(1)) << k_reg;

    // memory port steering
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end else if (cmd.check) begin
            rd_addr = (op_reg == OP_ALLOC) ? '0 : free_idx;
        end else if (cmd.look) begin
            rd_addr = IW'(1);
        end else if (cmd.descend) begin
            rd_addr = {desc_idx[IW-2:0], 1'b1};
        end else if (cmd.mark) begin
            rd_addr = sib_idx;
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = mark_val;
        end else if (cmd.ascend) begin
            rd_addr = par_sib;
            wr_en   = 1'b1;
            wr_addr = par_idx;
            wr_data = merged;
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) tree_mem[wr_addr] <= wr_data;
        rd_reg <= tree_mem[rd_addr];
    end

    always_comb begin
        k_next      = k_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        size_next   = size_reg;
        val_next    = val_reg;
        total_next  = total_reg;
        boff_next   = boff_reg;
        status_next = status_reg;
        priority if (cmd.check) begin
            k_next      = k_calc;
            n_next      = NW'(1) << k_calc;
            status_next = chk_code;
            idx_next    = (op_reg == OP_ALLOC) ? '0 : free_idx;
            size_next   = (op_reg == OP_ALLOC) ? POOL : NW'(1) << k_calc;
        end else if (cmd.look) begin
            if (look_fail) begin
                status_next = (op_reg == OP_ALLOC) ? STATUS_NO_SPACE : STATUS_MALFORMED;
            end
        end else if (cmd.descend) begin
            idx_next  = desc_idx;
            size_next = size_reg >> 1;
        end else if (cmd.mark) begin
            val_next  = mark_val;
            boff_next = off_full[POOL_ORDER-1:0];
            if (op_reg == OP_ALLOC) begin
                total_next = (total_reg > n_reg) ? total_reg - n_reg : '0;
            end else begin
                total_next = ((POOL - total_reg) > n_reg) ? total_reg + n_reg : POOL;
            end
        end else if (cmd.ascend) begin
            val_next  = merged;
            idx_next  = par_idx;
            size_next = psize;
        end else begin
            k_next = k_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            total_reg <= '0;
        end else begin
            if (cmd.clear) clr_reg <= clr_reg + IW'(1);
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_op;
            count_reg  <= in_count;
            offset_reg <= in_offset;
        end
        k_reg      <= k_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        size_reg   <= size_next;
        val_reg    <= val_next;
        boff_reg   <= boff_next;
        status_reg <= status_next;
    end

    assign sts.clr_last    = &clr_reg;
    assign sts.chk_fail    = (chk_code != STATUS_DONE);
    assign sts.look_fail   = look_fail;
    assign sts.reach_now   = (size_reg == n_reg);
    assign sts.reach_next  = ((size_reg >> 1) == n_reg);
    assign sts.at_root     = (idx_reg == '0);
    assign sts.parent_root = (par_idx == '0);

    assign res_status = status_reg;
    assign res_offset = (status_reg == STATUS_DONE && op_reg == OP_ALLOC) ? boff_reg : '0;
    assign res_pages  = (status_reg == STATUS_DONE) ? n_reg : '0;
    assign res_free   = total_reg;

endmodule

@@ hw/rtl/buddy_tree_page_allocator_top.sv @@
// Buddy tree page allocator: after reset a clearing pass zeroes all 2^(POOL_ORDER+1)
// tree slots (2048 by default); s_tready stays low meanwhile.
// Requests are served one at a time: s_tready is high only in the idle state, which
// is reached once the result is loaded into the output register; while an earlier
// result still waits on m_tready, the finish state holds. m_tvalid rises as the
// controller returns to idle. One tree read and write per level; sync reset.
module buddy_tree_page_allocator_top #(
    parameter  int POOL_ORDER = 10,
    localparam int IN_W  = ((2 * POOL_ORDER + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((3 * POOL_ORDER + 2 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // page_count, page_offset
    input  logic             s_tuser,   // operation
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // block_offset, block_pages, free page total
    output logic [1:0]       m_tuser    // status
);
    import bta_pkg::*;

    cmd_t                  cmd;
    sts_t                  sts;
    logic                  out_free;
    status_t               res_status;
    logic [POOL_ORDER-1:0] res_offset;
    logic [POOL_ORDER:0]   res_pages, res_free;

    logic                  m_tvalid_reg;
    status_t               o_status_reg;
    logic [POOL_ORDER-1:0] o_offset_reg;
    logic [POOL_ORDER:0]   o_pages_reg, o_free_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    bta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    bta_dp #(
        .POOL_ORDER (POOL_ORDER)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_count   (s_tdata[POOL_ORDER:0]),
        .in_offset  (s_tdata[2*POOL_ORDER:POOL_ORDER+1]),
        .res_status (res_status),
        .res_offset (res_offset),
        .res_pages  (res_pages),
        .res_free   (res_free)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && out_free) begin
            o_status_reg <= res_status;
            o_offset_reg <= res_offset;
            o_pages_reg  <= res_pages;
            o_free_reg   <= res_free;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = OUT_W'({o_free_reg, o_pages_reg, o_offset_reg});

endmodule

@@ sim/tb_buddy_tree_page_allocator_top.sv @@
// Testbench for the buddy tree page allocator: directed and random requests on the
// request stream, results checked item by item against a tree predictor held here.
// Depends on bta_pkg and buddy_tree_page_allocator_top.
`timescale 1ns / 1ps

module tb_buddy_tree_page_allocator_top;
    import bta_pkg::*;

    localparam int POOL_ORDER   = 10;
    localparam int POOL_PAGES   = 1 << POOL_ORDER;
    localparam int TREE_NODES   = 2 * POOL_PAGES - 1;
    localparam int RANDOM_ITEMS = 1840;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic        op;
        logic [10:0] count;
        logic [9:0]  offs;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  offset;
        logic [10:0] pages;
        logic [10:0] total_free;
    } outcome_t;

    typedef struct packed {
        logic [9:0]  offset;
        logic [10:0] pages;
    } block_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = OP_ALLOC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    request_t          pending_requests[$];
    outcome_t          due_outcomes[$];
    block_t            live_blocks[$];
    block_t            last_freed = '{10'd0, 11'd1};
    logic [POOL_ORDER:0] span_tree[TREE_NODES];
    logic [POOL_ORDER:0] free_total = '0;

    int  sent_cnt     = 0;
    int  accepted_cnt = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  cycle_count  = 0;
    int  errors       = 0;
    logic quiet       = 1'b0;

    buddy_tree_page_allocator_top #(.POOL_ORDER(POOL_ORDER)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    endtask

    task automatic queue_request(input logic op, input int count, input int offs);
        pending_requests.push_back('{op, count[10:0], offs[9:0]});
    endtask

    // Applies one request to the local tree and returns the result it should give.
    function automatic outcome_t serve_request(input logic op, input logic [10:0] count,
                                               input logic [9:0] offs);
        outcome_t res;
        int n, size, idx, left, shift, l, r, hit;
        res = '{STATUS_DONE, 10'd0, 11'd0, 11'd0};
        if (op == OP_ALLOC) begin
            if (count == 0) begin
                res.status = STATUS_MALFORMED;
            end else if (count > POOL_PAGES) begin
                res.status = STATUS_NO_SPACE;
            end else begin
                n = 1;
                while (n < count) n = n << 1;
                if (span_tree[0] < n) begin
                    res.status = STATUS_NO_SPACE;
                end else begin
                    idx = 0;
                    for (size = POOL_PAGES; size != n; size = size >> 1) begin
                        left = 2 * idx + 1;
                        idx = (span_tree[left] >= n) ? left : left + 1;
                    end
                    res.offset = 10'((idx + 1) * size - POOL_PAGES);
                    span_tree[idx] = '0;
                    while (idx != 0) begin
                        idx = (idx - 1) / 2;
                        l = int'(span_tree[2 * idx + 1]);
                        r = int'(span_tree[2 * idx + 2]);
                        span_tree[idx] = 11'((l > r) ? l : r);
                    end
                    free_total = (free_total > n) ? free_total - 11'(n) : '0;
                    res.pages = 11'(n);
                    live_blocks.push_back('{res.offset, res.pages});
                end
            end
        end else begin
            n = int'(count);
            if (n == 0 || n > POOL_PAGES || (n & (n - 1)) != 0 || (offs & (n - 1)) != 0) begin
                res.status = STATUS_MALFORMED;
            end else begin
                shift = 0;
                while ((1 << shift) != n) shift++;
                idx = ((int'(offs) + POOL_PAGES) >> shift) - 1;
                if (span_tree[idx] != 0) begin
                    res.status = STATUS_MALFORMED;
                end else begin
                    span_tree[idx] = 11'(n);
                    size = n;
                    while (idx != 0) begin
                        idx = (idx - 1) / 2;
                        size = size << 1;
                        l = int'(span_tree[2 * idx + 1]);
                        r = int'(span_tree[2 * idx + 2]);
                        span_tree[idx] = 11'((l + r == size) ? size : ((l > r) ? l : r));
                    end
                    free_total = (POOL_PAGES - free_total > n) ? free_total + 11'(n)
                                                                : 11'(POOL_PAGES);
                    res.pages = 11'(n);
                    hit = -1;
                    foreach (live_blocks[i])
                        if (hit < 0 && live_blocks[i].offset == offs && live_blocks[i].pages == n)
                            hit = i;
                    if (hit >= 0) live_blocks.delete(hit);
                    last_freed = '{offs, res.pages};
                end
            end
        end
        res.total_free = free_total;
        return res;
    endfunction

    always @(negedge aclk) begin : drive_requests
        request_t req;
        if (!s_tvalid || accepted_cnt == sent_cnt) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                req = pending_requests.pop_front();
                s_tuser  <= req.op;
                s_tdata  <= {3'b000, req.offs, req.count};
                s_tvalid <= 1'b1;
                sent_cnt++;
                gap_left = draw_wait();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        outcome_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                stall_left = draw_wait();
                if (due_outcomes.size() == 0) begin
                    report_mismatch("result with nothing pending, status", int'(m_tuser), 0);
                end else begin
                    want = due_outcomes.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", int'(m_tuser), int'(want.status));
                    if (m_tdata[9:0] != want.offset)
                        report_mismatch("block_offset", int'(m_tdata[9:0]),
                                        int'(want.offset));
                    if (m_tdata[20:10] != want.pages)
                        report_mismatch("block_pages", int'(m_tdata[20:10]),
                                        int'(want.pages));
                    if (m_tdata[31:21] != want.total_free)
                        report_mismatch("free page total", int'(m_tdata[31:21]),
                                        int'(want.total_free));
                end
            end
            if (s_tvalid && s_tready) begin
                due_outcomes.push_back(serve_request(s_tuser, s_tdata[10:0], s_tdata[20:11]));
                accepted_cnt++;
            end
        end
    end

    // Frees the pool in granules: 4 pages over the first quarter, 16 over the rest.
    task automatic seed_pool();
        for (int off = 0; off < 256; off += 4) queue_request(OP_FREE, 4, off);
        for (int off = 256; off < POOL_PAGES; off += 16) queue_request(OP_FREE, 16, off);
    endtask

    initial begin
        int pick, sel, size, base, idx;
        foreach (span_tree[i]) span_tree[i] = '0;

        queue_request(OP_ALLOC, 1, 0);
        queue_request(OP_ALLOC, 0, 0);
        queue_request(OP_FREE, 0, 0);
        queue_request(OP_FREE, 3, 0);
        queue_request(OP_FREE, 2047, 0);
        queue_request(OP_FREE, 4, 2);
        queue_request(OP_FREE, 2, 1023);
        queue_request(OP_FREE, 1024, 0);
        queue_request(OP_FREE, 1024, 0);
        queue_request(OP_ALLOC, 2047, 0);
        queue_request(OP_ALLOC, 1025, 0);
        queue_request(OP_ALLOC, 1024, 1023);
        queue_request(OP_ALLOC, 1, 0);
        queue_request(OP_FREE, 1024, 0);
        queue_request(OP_ALLOC, 512, 0);
        queue_request(OP_FREE, 512, 512);
        queue_request(OP_FREE, 512, 0);
        queue_request(OP_ALLOC, 600, 0);
        queue_request(OP_FREE, 1, 1023);
        queue_request(OP_ALLOC, 1, 0);
        seed_pool();

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            while (pending_requests.size() != 0 || accepted_cnt != sent_cnt) @(negedge aclk);
            quiet = (k % 300) < 40;
            if (k == RANDOM_ITEMS / 2)
                while (due_outcomes.size() != 0) @(negedge aclk);
            if (span_tree[0] < 4 && live_blocks.size() == 0) seed_pool();
            pick = $urandom_range(0, 99);
            if (pick < 75 && live_blocks.size() != 0 && (pick >= 38 || span_tree[0] < 4)) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                queue_request(OP_FREE, int'(live_blocks[idx].pages),
                              int'(live_blocks[idx].offset));
            end else if (pick < 75) begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    queue_request(OP_ALLOC, $urandom_range(3, 64), $urandom_range(0, 1023));
                else if (sel < 9)
                    queue_request(OP_ALLOC, $urandom_range(65, 1024), $urandom_range(0, 1023));
                else
                    queue_request(OP_ALLOC, $urandom_range(1, 2), $urandom_range(0, 1023));
            end else if (pick < 82) begin
                queue_request(OP_FREE, int'(last_freed.pages), int'(last_freed.offset));
            end else if (pick < 90) begin
                size = 1 << $urandom_range(1, POOL_ORDER);
                base = $urandom_range(0, 1023) & ~(size - 1);
                if ($urandom_range(0, 1))
                    queue_request(OP_FREE, size, (base | $urandom_range(1, size - 1)) & 1023);
                else
                    queue_request(OP_FREE, size + $urandom_range(1, size - 1), base);
            end else begin
                queue_request(1'($urandom_range(0, 1)),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(1025, 2047)
                                                          : $urandom_range(0, 1024),
                              $urandom_range(0, 1023));
            end
        end

        quiet = 1'b0;
        while (pending_requests.size() != 0 || accepted_cnt != sent_cnt) @(negedge aclk);
        while (due_outcomes.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/bta_pkg.sv
hw/rtl/bta_ctrl.sv
hw/rtl/bta_dp.sv
hw/rtl/buddy_tree_page_allocator_top.sv
sim/tb_buddy_tree_page_allocator_top.sv
